>>> hw/rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/nww_pkg.sv
// constants, types and codes for the nearest waypoint window block
// no dependencies
package nww_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int MAX_WINDOW = 32;
    localparam int ELEM_W     = 16;
    localparam int NUM_ELEM   = 10;

    localparam int IDX_W      = $clog2(MAX_POINTS);
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int WIN_W      = $clog2(MAX_WINDOW + 1);
    localparam int PT_W       = NUM_ELEM * ELEM_W;
    localparam int IN_DATA_W  = ((IDX_W + PT_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((IDX_W + PT_W + 7) / 8) * 8;
    localparam int SQ_W       = 2 * (ELEM_W + 1);
    localparam int SUM_W      = SQ_W + 2;

    localparam int PC_W       = 11;
    localparam int WL_W       = 6;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [PC_W-1:0] PC_RESET = PC_W'(1024);
    localparam logic [WL_W-1:0] WL_RESET = WL_W'(16);

    typedef enum logic [0:0] {
        REG_POINT_COUNT   = 1'b0,
        REG_WINDOW_LENGTH = 1'b1
    } reg_sel_t;

    typedef enum logic [0:0] {
        CMD_LOAD  = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_code_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_START,
        ST_EMIT_RD,
        ST_EMIT_LD
    } state_t;

    typedef struct packed {
        logic mem_write;
        logic latch_query;
        logic scan_issue;
        logic set_start;
        logic emit_rd;
        logic emit_load;
    } nww_cmd_t;

    typedef struct packed {
        logic scan_last;
        logic pipe_busy;
        logic emit_last;
        logic out_free;
    } nww_stat_t;

endpackage

>>> hw/rtl/nearest_waypoint_window.sv
// A load beat writes one ten-element point into the 1024-entry store.
// A query beat scans store entries 0 to point_count-1, with point_count clamped to
// 1..1024, through a single read port, one per cycle, with a distance pipeline
// (squares, sum, best compare) behind it; the window then streams out beat by beat
// (read, then output register), waiting while the output register is full. One item
// is worked at a time; the last beat may wait in the output register while the next
// item is taken. There is no clearing pass after reset, and store entries must be
// loaded before a query reaches them.
// top level: apb registers, controller and datapath; depends on nww_pkg,
// nww_ctrl, nww_datapath and assert_macros.svh
`include "assert_macros.svh"

module nearest_waypoint_window
(
    input  logic                            clk,
    input  logic                            rst_n,
    // tdata: point_index, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
    //        quat_w, quat_x, quat_y, quat_z, zero pad
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [nww_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // tuser: cmd
    input  logic                            s_axis_tuser,
    // tdata: start_index, out_pos_x, out_pos_y, out_pos_z, out_vel_x, out_vel_y,
    //        out_vel_z, out_quat_w, out_quat_x, out_quat_y, out_quat_z, zero pad
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [nww_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic                            m_axis_tlast,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [nww_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [nww_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [nww_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);
    import nww_pkg::*;

    logic [PC_W-1:0] point_count_reg;
    logic [WL_W-1:0] window_length_reg;
    logic            cfg_wr;
    reg_sel_t        reg_sel;
    nww_cmd_t        dp_cmd;
    nww_stat_t       dp_stat;
    logic            in_query;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_sel = reg_sel_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            point_count_reg   <= PC_RESET;
            window_length_reg <= WL_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_POINT_COUNT:   point_count_reg   <= pwdata[PC_W-1:0];
                REG_WINDOW_LENGTH: window_length_reg <= pwdata[WL_W-1:0];
                default:           point_count_reg   <= point_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_POINT_COUNT:   prdata = APB_DATA_W'(point_count_reg);
            REG_WINDOW_LENGTH: prdata = APB_DATA_W'(window_length_reg);
            default:           prdata = '0;
        endcase
    end

    assign in_query = (s_axis_tuser == CMD_QUERY);

    nww_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_query (in_query),
        .in_ready (s_axis_tready),
        .stat     (dp_stat),
        .cmd      (dp_cmd)
    );

    nww_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (dp_cmd),
        .stat          (dp_stat),
        .in_data       (s_axis_tdata),
        .point_count   (point_count_reg),
        .window_length (window_length_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_data      (m_axis_tdata),
        .out_last      (m_axis_tlast)
    );

    `ASSERT_NEXT(a_query_leaves_idle, clk, rst_n, s_axis_tvalid && s_axis_tready && in_query, !s_axis_tready, "query beat did not start a search")
    `ASSERT_IMPL(a_busy_blocks_input, clk, rst_n, dp_stat.pipe_busy, !s_axis_tready, "input taken while distance pipeline busy")
    `ASSERT_IMPL(a_emit_into_free_reg, clk, rst_n, dp_cmd.emit_load, dp_stat.out_free, "window beat overwrote a pending output beat")

endmodule

>>> hw/rtl/nww_ctrl.sv
// controller state machine for the nearest waypoint window block
// depends on nww_pkg
module nww_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_query,
    output logic                in_ready,
    input  nww_pkg::nww_stat_t  stat,
    output nww_pkg::nww_cmd_t   cmd
);
    import nww_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_query)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (stat.scan_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                state_next = ST_EMIT_RD;
            end
            ST_EMIT_RD:
            begin
                state_next = ST_EMIT_LD;
            end
            ST_EMIT_LD:
            begin
                if (stat.out_free)
                begin
                    state_next = stat.emit_last ? ST_IDLE : ST_EMIT_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready        = 1'b1;
                cmd.mem_write   = in_valid && !in_query;
                cmd.latch_query = in_valid && in_query;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
            end
            ST_DRAIN:
            begin
                cmd = '0;
            end
            ST_START:
            begin
                cmd.set_start = 1'b1;
            end
            ST_EMIT_RD:
            begin
                cmd.emit_rd = 1'b1;
            end
            ST_EMIT_LD:
            begin
                cmd.emit_load = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> hw/rtl/nww_datapath.sv
// point store, distance pipeline, best tracker and output register
// depends on nww_pkg
module nww_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  nww_pkg::nww_cmd_t              cmd,
    output nww_pkg::nww_stat_t             stat,
    input  logic [nww_pkg::IN_DATA_W-1:0]  in_data,
    input  logic [nww_pkg::PC_W-1:0]       point_count,
    input  logic [nww_pkg::WL_W-1:0]       window_length,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [nww_pkg::OUT_DATA_W-1:0] out_data,
    output logic                           out_last
);
    import nww_pkg::*;

    logic [PT_W-1:0] mem [MAX_POINTS];
    logic [PT_W-1:0] rd_data_reg;
    logic            rd_en;
    logic [IDX_W-1:0] rd_addr;

    logic signed [ELEM_W-1:0] qx_reg, qy_reg, qz_reg;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIN_W-1:0] win_reg, win_next;

    logic [IDX_W-1:0] scan_addr_reg;
    logic             p1_vld_reg, p2_vld_reg, p3_vld_reg;
    logic [IDX_W-1:0] p1_idx_reg, p2_idx_reg, p3_idx_reg;

    logic signed [ELEM_W:0]   dx, dy, dz;
    logic signed [SQ_W-1:0]   sqx, sqy, sqz;
    logic [SQ_W-1:0]          sqx_reg, sqy_reg, sqz_reg;
    logic [SUM_W-1:0]         sum_reg, sum_next;
    logic [SUM_W-1:0]         best_d_reg;
    logic [IDX_W-1:0]         best_reg;

    logic [IDX_W-1:0] start_reg, start_next;
    logic [CNT_W-1:0] start_lim;
    logic [WIN_W-1:0] emit_i_reg;
    logic [IDX_W-1:0] emit_addr;

    logic                  out_vld_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_last_reg;

    // clamp the configuration at query time
    always_comb
    begin
        if (point_count == '0)
        begin
            cnt_next = CNT_W'(1);
        end
        else if (32'(point_count) > MAX_POINTS)
        begin
            cnt_next = CNT_W'(MAX_POINTS);
        end
        else
        begin
            cnt_next = CNT_W'(point_count);
        end
        if (window_length == '0)
        begin
            win_next = WIN_W'(1);
        end
        else if (32'(window_length) > MAX_WINDOW)
        begin
            win_next = WIN_W'(MAX_WINDOW);
        end
        else
        begin
            win_next = WIN_W'(window_length);
        end
        if (32'(win_next) > 32'(cnt_next))
        begin
            win_next = WIN_W'(cnt_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_query)
        begin
            qx_reg  <= in_data[IDX_W +: ELEM_W];
            qy_reg  <= in_data[IDX_W + ELEM_W +: ELEM_W];
            qz_reg  <= in_data[IDX_W + 2*ELEM_W +: ELEM_W];
            cnt_reg <= cnt_next;
            win_reg <= win_next;
        end
    end

    // single-port store: one write or one read per cycle
    assign emit_addr = start_reg + IDX_W'(emit_i_reg);
    assign rd_en     = cmd.scan_issue || cmd.emit_rd;
    assign rd_addr   = cmd.scan_issue ? scan_addr_reg : emit_addr;

    always_ff @(posedge clk)
    begin
        if (cmd.mem_write)
        begin
            mem[in_data[IDX_W-1:0]] <= in_data[IDX_W +: PT_W];
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // scan address counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_addr_reg <= '0;
        end
        else if (cmd.latch_query)
        begin
            scan_addr_reg <= '0;
        end
        else if (cmd.scan_issue)
        begin
            scan_addr_reg <= scan_addr_reg + IDX_W'(1);
        end
    end

    // distance pipeline
    assign dx = $signed({rd_data_reg[ELEM_W-1], rd_data_reg[ELEM_W-1:0]})
              - $signed({qx_reg[ELEM_W-1], qx_reg});
    assign dy = $signed({rd_data_reg[2*ELEM_W-1], rd_data_reg[ELEM_W +: ELEM_W]})
              - $signed({qy_reg[ELEM_W-1], qy_reg});
    assign dz = $signed({rd_data_reg[3*ELEM_W-1], rd_data_reg[2*ELEM_W +: ELEM_W]})
              - $signed({qz_reg[ELEM_W-1], qz_reg});
    assign sqx = dx * dx;
    assign sqy = dy * dy;
    assign sqz = dz * dz;
    assign sum_next = SUM_W'(sqx_reg) + SUM_W'(sqy_reg) + SUM_W'(sqz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
        end
        else
        begin
            p1_vld_reg <= cmd.scan_issue;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= p2_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        p1_idx_reg <= scan_addr_reg;
        p2_idx_reg <= p1_idx_reg;
        p3_idx_reg <= p2_idx_reg;
        sqx_reg    <= $unsigned(sqx);
        sqy_reg    <= $unsigned(sqy);
        sqz_reg    <= $unsigned(sqz);
        sum_reg    <= sum_next;
        if (p3_vld_reg && (p3_idx_reg == '0 || sum_reg < best_d_reg))
        begin
            best_d_reg <= sum_reg;
            best_reg   <= p3_idx_reg;
        end
    end

    // window start with wrap to zero
    assign start_lim  = cnt_reg - CNT_W'(win_reg);
    assign start_next = (CNT_W'(best_reg) > start_lim) ? '0 : best_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.set_start)
        begin
            start_reg <= start_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            emit_i_reg <= '0;
        end
        else if (cmd.set_start)
        begin
            emit_i_reg <= '0;
        end
        else if (cmd.emit_load)
        begin
            emit_i_reg <= emit_i_reg + WIN_W'(1);
        end
    end

    // output register, holds one beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.emit_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_load)
        begin
            out_data_reg <= OUT_DATA_W'({rd_data_reg, start_reg});
            out_last_reg <= stat.emit_last;
        end
    end

    assign stat.scan_last = (CNT_W'(scan_addr_reg) == cnt_reg - CNT_W'(1));
    assign stat.pipe_busy = p1_vld_reg || p2_vld_reg || p3_vld_reg;
    assign stat.emit_last = (emit_i_reg == win_reg - WIN_W'(1));
    assign stat.out_free  = !out_vld_reg || out_ready;

    assign out_valid = out_vld_reg;
    assign out_data  = out_data_reg;
    assign out_last  = out_last_reg;

endmodule
